// ----- rtl/pps_pkg.sv -----
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types, widths, constants and tables for the pursuit steering unit.
// ----------------------------------------------------------------------------
package pps_pkg;

  // defaults for top level parameters
  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned COORD_WIDTH_DEF   = 16;

  // field widths
  localparam int unsigned FIELD_W = 16;  // coordinate ports
  localparam int unsigned HEAD_W  = 16;
  localparam int unsigned STOP_W  = 15;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned LIN_W   = 15;
  localparam int unsigned ANG_W   = 16;

  // internal widths, sized for the widest coordinate (16 bits)
  localparam int unsigned DIFF_W   = FIELD_W + 1;     // target - own
  localparam int unsigned SQ_W     = 2 * DIFF_W;      // dx^2 + dy^2
  localparam int unsigned STOPSQ_W = 2 * STOP_W;
  localparam int unsigned ROOT_W   = DIFF_W;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned XY_W     = DIFF_W + 16 + 3; // Q.16 plus CORDIC growth
  localparam int unsigned Z_W      = 35;              // Q2.30 plus headroom
  localparam int unsigned BEAR_W   = 17;
  localparam int unsigned ERR_W    = BEAR_W + 1;
  localparam int unsigned LIN_P_W  = ROOT_W + GAIN_W;
  localparam int unsigned ANG_P_W  = ERR_W + GAIN_W + 1;
  localparam int unsigned ATAN_N   = 24;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_DISTANCE = 2'd0,
    CFG_LINEAR_GAIN   = 2'd1,
    CFG_ANGULAR_GAIN  = 2'd2
  } cfg_idx_e;

  localparam logic [STOP_W-1:0] STOP_DIST_RST = 15'd1024;  // 1.0
  localparam logic [GAIN_W-1:0] LIN_GAIN_RST  = 16'd4915;  // 0.3
  localparam logic [GAIN_W-1:0] ANG_GAIN_RST  = 16'd7373;  // 0.3 * 1.5

  localparam logic signed [Z_W-1:0] PI_Q30 = 35'sd3373259426;

  // word travelling down the row of cells
  typedef struct packed {
    logic signed [XY_W-1:0]   x;
    logic signed [XY_W-1:0]   y;
    logic signed [Z_W-1:0]    z;
    logic        [SQ_W-1:0]   n;     // radicand, consumed two bits per square root cell
    logic        [REM_W-1:0]  rem;
    logic        [ROOT_W-1:0] root;
    logic signed [HEAD_W-1:0] heading;
    logic                     zero;  // dx == dy == 0
    logic                     pursue;
  } pps_cell_t;

  typedef struct packed {
    logic        [LIN_W-1:0] linear_speed;
    logic signed [ANG_W-1:0] angular_speed;
    logic                    pursuing;
  } pps_result_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [Z_W-1:0] atan_q30(input int unsigned idx);
    logic signed [Z_W-1:0] v;
    unique case (idx)
      0:       v = 35'sd843314857;
      1:       v = 35'sd497837829;
      2:       v = 35'sd263043837;
      3:       v = 35'sd133525159;
      4:       v = 35'sd67021687;
      5:       v = 35'sd33543516;
      6:       v = 35'sd16775851;
      7:       v = 35'sd8388437;
      8:       v = 35'sd4194283;
      9:       v = 35'sd2097149;
      10:      v = 35'sd1048576;
      11:      v = 35'sd524288;
      12:      v = 35'sd262144;
      13:      v = 35'sd131072;
      14:      v = 35'sd65536;
      15:      v = 35'sd32768;
      16:      v = 35'sd16384;
      17:      v = 35'sd8192;
      18:      v = 35'sd4096;
      19:      v = 35'sd2048;
      20:      v = 35'sd1024;
      21:      v = 35'sd512;
      22:      v = 35'sd256;
      23:      v = 35'sd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pursuit_proportional_steering_unit.sv -----
// ----------------------------------------------------------------------------
// pursuit_proportional_steering_unit
// Go-to-goal proportional steering: distance and bearing to the target, then
// linear and angular speed commands from two gains, zero inside stop distance.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o | target_x/y, own_x/y, heading
//   out     | output    | out_valid_o/out_stall_i | linear/angular speed, pursuing
//   cfg     | input     | cfg_we_i                | cfg_index_i, cfg_data_i
//
// One word per cycle while in_stall_o is low. The row holds N = max(CORDIC_STAGES,
// min(COORD_WIDTH,16) + 1) cells (17 at the defaults). The pipeline is made of
// three front stages, the row of cells, three finishing stages and the output
// register.
// Reset loads the register defaults and clears all valid bits.
// A stalled result waits in the output register; one more word lands in the
// skid register, and only while that is full is the input stalled.
// ----------------------------------------------------------------------------
module pursuit_proportional_steering_unit #(
  parameter int unsigned CORDIC_STAGES = pps_pkg::CORDIC_STAGES_DEF,
  parameter int unsigned COORD_WIDTH   = pps_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [pps_pkg::FIELD_W-1:0]  target_x_i,
  input  logic signed [pps_pkg::FIELD_W-1:0]  target_y_i,
  input  logic signed [pps_pkg::FIELD_W-1:0]  own_x_i,
  input  logic signed [pps_pkg::FIELD_W-1:0]  own_y_i,
  input  logic signed [pps_pkg::HEAD_W-1:0]   own_heading_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic        [pps_pkg::LIN_W-1:0]    linear_speed_o,
  output logic signed [pps_pkg::ANG_W-1:0]    angular_speed_o,
  output logic                                pursuing_o,
  input  logic                                cfg_we_i,
  input  logic        [pps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [pps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import pps_pkg::*;

  localparam int unsigned CWE        = (COORD_WIDTH > FIELD_W) ? FIELD_W : COORD_WIDTH;
  localparam int unsigned ROOT_STEPS = CWE + 1;
  localparam int unsigned ALIGN      = SQ_W - 2 * ROOT_STEPS;
  localparam int unsigned N_CELLS    = (CORDIC_STAGES > ROOT_STEPS) ? CORDIC_STAGES
                                                                    : ROOT_STEPS;

  // configuration
  logic [STOP_W-1:0]   stop_q;
  logic [GAIN_W-1:0]   lin_gain_q, ang_gain_q;
  logic [STOPSQ_W-1:0] stop_sq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q     <= STOP_DIST_RST;
      lin_gain_q <= LIN_GAIN_RST;
      ang_gain_q <= ANG_GAIN_RST;
      stop_sq_q  <= STOPSQ_W'(STOP_DIST_RST * STOP_DIST_RST);
    end else begin
      stop_sq_q <= STOPSQ_W'(stop_q * stop_q);
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_STOP_DISTANCE: stop_q     <= cfg_data_i[STOP_W-1:0];
          CFG_LINEAR_GAIN:   lin_gain_q <= cfg_data_i[GAIN_W-1:0];
          CFG_ANGULAR_GAIN:  ang_gain_q <= cfg_data_i[GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // pipeline advances unless the skid register holds a word
  logic en;
  logic skid_valid_q, out_valid_q;
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // front stage 1: differences
  logic signed [CWE-1:0]    tx_c, ty_c, ox_c, oy_c;
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  logic signed [HEAD_W-1:0] head1_q, head2_q;
  logic [2:0]               front_v_q;

  always_comb begin
    tx_c = target_x_i[CWE-1:0];
    ty_c = target_y_i[CWE-1:0];
    ox_c = own_x_i[CWE-1:0];
    oy_c = own_y_i[CWE-1:0];
    dx_d = {{(DIFF_W-CWE){tx_c[CWE-1]}}, tx_c} - {{(DIFF_W-CWE){ox_c[CWE-1]}}, ox_c};
    dy_d = {{(DIFF_W-CWE){ty_c[CWE-1]}}, ty_c} - {{(DIFF_W-CWE){oy_c[CWE-1]}}, oy_c};
  end

  // front stage 2: squares and left half plane turn
  logic signed [SQ_W-1:0] sqx_d, sqy_d;
  logic [SQ_W-1:0]        sqx_q, sqy_q;
  logic signed [XY_W-1:0] x0, y0, x0_q, y0_q;
  logic signed [Z_W-1:0]  z0, z0_q;
  logic                   zero_q;

  always_comb begin
    sqx_d = dx_q * dx_q;
    sqy_d = dy_q * dy_q;
    x0 = {{(XY_W-DIFF_W-16){dx_q[DIFF_W-1]}}, dx_q, 16'b0};
    y0 = {{(XY_W-DIFF_W-16){dy_q[DIFF_W-1]}}, dy_q, 16'b0};
    z0 = '0;
    if (dx_q < 0) begin
      z0 = (dy_q >= 0) ? PI_Q30 : -PI_Q30;
      x0 = -x0;
      y0 = -y0;
    end
  end

  // front stage 3: stop test, radicand aligned for ROOT_STEPS cells
  logic [SQ_W-1:0] sq_sum;
  pps_cell_t       s3_d, s3_q;

  always_comb begin
    sq_sum      = sqx_q + sqy_q;
    s3_d.x      = x0_q;
    s3_d.y      = y0_q;
    s3_d.z      = z0_q;
    s3_d.n      = sq_sum << ALIGN;
    s3_d.rem    = '0;
    s3_d.root   = '0;
    s3_d.heading = head2_q;
    s3_d.zero   = zero_q;
    s3_d.pursue = (sq_sum >= SQ_W'(stop_sq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_v_q <= '0;
    end else if (en) begin
      front_v_q <= {front_v_q[1:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      head1_q <= own_heading_i;
      sqx_q   <= $unsigned(sqx_d);
      sqy_q   <= $unsigned(sqy_d);
      x0_q    <= x0;
      y0_q    <= y0;
      z0_q    <= z0;
      zero_q  <= (dx_q == '0) && (dy_q == '0);
      head2_q <= head1_q;
      s3_q    <= s3_d;
    end
  end

  // row of cells
  pps_cell_t cell_q [N_CELLS];
  logic      cell_v [N_CELLS];

  for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_first
      pps_cell #(
        .IDX     (g),
        .ROT_EN  (g < CORDIC_STAGES),
        .SQRT_EN (g < ROOT_STEPS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (front_v_q[2]),
        .d_i     (s3_q),
        .valid_o (cell_v[g]),
        .q_o     (cell_q[g])
      );
    end else begin : g_next
      pps_cell #(
        .IDX     (g),
        .ROT_EN  (g < CORDIC_STAGES),
        .SQRT_EN (g < ROOT_STEPS)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (cell_v[g-1]),
        .d_i     (cell_q[g-1]),
        .valid_o (cell_v[g]),
        .q_o     (cell_q[g])
      );
    end
  end

  // finishing stages
  logic        fin_valid;
  pps_result_t fin_res;

  pps_finish u_finish (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .en_i           (en),
    .valid_i        (cell_v[N_CELLS-1]),
    .d_i            (cell_q[N_CELLS-1]),
    .linear_gain_i  (lin_gain_q),
    .angular_gain_i (ang_gain_q),
    .valid_o        (fin_valid),
    .res_o          (fin_res)
  );

  // output register and skid register
  pps_result_t out_q, skid_q;
  logic        out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= fin_valid;
      end
    end else if (en && fin_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : fin_res;
    end else if (en && fin_valid) begin
      skid_q <= fin_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign linear_speed_o  = out_q.linear_speed;
  assign angular_speed_o = out_q.angular_speed;
  assign pursuing_o      = out_q.pursuing;

`ifndef SYNTHESIS
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without an output word");

  a_skid_fill_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && out_stall_i))
    else $error("skid filled while output was free");

  a_skid_catches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && !skid_valid_q && fin_valid) |=> skid_valid_q)
    else $error("finished word lost under output stall");

  a_stop_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pursuing_o) |-> (linear_speed_o == '0 && angular_speed_o == '0))
    else $error("nonzero speed command while stopped");
`endif

endmodule

// ----- rtl/pps_cell.sv -----
// ----------------------------------------------------------------------------
// pps_cell
// One cell of the row: one CORDIC vectoring micro-rotation (ROT_EN) and one bit
// of the digit-by-digit square root (SQRT_EN), then a register toward the next cell.
// ----------------------------------------------------------------------------
module pps_cell #(
  parameter int unsigned IDX     = 0,
  parameter bit          ROT_EN  = 1'b1,
  parameter bit          SQRT_EN = 1'b1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  pps_pkg::pps_cell_t d_i,
  output logic               valid_o,
  output pps_pkg::pps_cell_t q_o
);
  import pps_pkg::*;

  pps_cell_t              cell_d, cell_q;
  logic                   valid_q;
  logic signed [XY_W-1:0] xs, ys;
  logic [REM_W-1:0]       rem_sh, trial;

  always_comb begin
    cell_d = d_i;
    xs     = d_i.x >>> IDX;
    ys     = d_i.y >>> IDX;
    rem_sh = {d_i.rem[REM_W-3:0], d_i.n[SQ_W-1 -: 2]};
    trial  = {d_i.root, 2'b01};
    if (ROT_EN) begin
      if (d_i.y > 0) begin
        cell_d.x = d_i.x + ys;
        cell_d.y = d_i.y - xs;
        cell_d.z = d_i.z + atan_q30(IDX);
      end else begin
        cell_d.x = d_i.x - ys;
        cell_d.y = d_i.y + xs;
        cell_d.z = d_i.z - atan_q30(IDX);
      end
    end
    if (SQRT_EN) begin
      cell_d.n = d_i.n << 2;
      if (rem_sh >= trial) begin
        cell_d.rem  = rem_sh - trial;
        cell_d.root = {d_i.root[ROOT_W-2:0], 1'b1};
      end else begin
        cell_d.rem  = rem_sh;
        cell_d.root = {d_i.root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign q_o     = cell_q;

endmodule

// ----- rtl/pps_finish.sv -----
// ----------------------------------------------------------------------------
// pps_finish
// Bearing rounding, heading error, gain products, rounding and saturation.
// Three register stages.
// ----------------------------------------------------------------------------
module pps_finish (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  pps_pkg::pps_cell_t           d_i,
  input  logic [pps_pkg::GAIN_W-1:0]   linear_gain_i,
  input  logic [pps_pkg::GAIN_W-1:0]   angular_gain_i,
  output logic                         valid_o,
  output pps_pkg::pps_result_t         res_o
);
  import pps_pkg::*;

  localparam int unsigned LIN_SH_W = LIN_P_W - 14;
  localparam int unsigned ANG_SH_W = ANG_P_W - 14;
  localparam logic signed [ANG_SH_W-1:0] ANG_MAX = ANG_SH_W'(32767);
  localparam logic signed [ANG_SH_W-1:0] ANG_MIN = -ANG_SH_W'(32768);

  logic [2:0] valid_q;

  // stage 1
  logic signed [Z_W-1:0]    z_rnd;
  logic signed [BEAR_W-1:0] bearing;
  logic signed [ERR_W-1:0]  err_d, err_q;
  logic [ROOT_W-1:0]        root_q;
  logic                     pursue1_q;

  // stage 2
  logic [LIN_P_W-1:0]         lin_p_q;
  logic signed [ANG_P_W-1:0]  ang_p_q;
  logic                       pursue2_q;

  // stage 3
  logic [LIN_P_W-1:0]         lin_sum;
  logic [LIN_SH_W-1:0]        lin_sh;
  logic signed [ANG_P_W-1:0]  ang_sum;
  logic signed [ANG_SH_W-1:0] ang_sh;
  pps_result_t                res_d, res_q;

  always_comb begin
    z_rnd   = d_i.z + Z_W'(1 << 17);
    bearing = d_i.zero ? '0 : z_rnd[18 +: BEAR_W];
    err_d   = {bearing[BEAR_W-1], bearing}
            - {{(ERR_W-HEAD_W){d_i.heading[HEAD_W-1]}}, d_i.heading};
  end

  always_comb begin
    lin_sum = lin_p_q + LIN_P_W'(1 << 13);
    lin_sh  = lin_sum[LIN_P_W-1:14];
    ang_sum = ang_p_q + ANG_P_W'(1 << 13);
    ang_sh  = ang_sum[ANG_P_W-1:14];
    res_d   = '0;
    if (pursue2_q) begin
      res_d.pursuing = 1'b1;
      if (|lin_sh[LIN_SH_W-1:LIN_W]) begin
        res_d.linear_speed = '1;
      end else begin
        res_d.linear_speed = lin_sh[LIN_W-1:0];
      end
      priority if (ang_sh > ANG_MAX) begin
        res_d.angular_speed = ANG_MAX[ANG_W-1:0];
      end else if (ang_sh < ANG_MIN) begin
        res_d.angular_speed = ANG_MIN[ANG_W-1:0];
      end else begin
        res_d.angular_speed = ang_sh[ANG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      err_q     <= err_d;
      root_q    <= d_i.root;
      pursue1_q <= d_i.pursue;
      lin_p_q   <= LIN_P_W'(root_q * linear_gain_i);
      ang_p_q   <= $signed({1'b0, angular_gain_i}) * err_q;
      pursue2_q <= pursue1_q;
      res_q     <= res_d;
    end
  end

  assign valid_o = valid_q[2];
  assign res_o   = res_q;

endmodule
